>>> src/fnvdf_pkg.sv
`timescale 1ns / 1ps
package fnvdf_pkg;

	// Hash constants. The 64-bit prime is 2^40 + 0x1B3, so the multiply
	// is done as a shift plus a narrow constant product.
	localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
	localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
	localparam int          FNV_PRIME_SHIFT = 40;

	// Only the first bytes of a record up to this limit are hashed.
	localparam int HASH_BYTE_LIMIT = 256;
	localparam int COUNT_W         = $clog2(HASH_BYTE_LIMIT + 1);

	// Number of recent distinct ids kept in the window chain.
	localparam int WINDOW_DEPTH = 25;

	localparam int ID_W   = 64;
	localparam int BYTE_W = 8;

	// Control that every window cell receives in the same cycle.
	typedef struct packed {
		logic shift;
	} cell_ctrl_t;

endpackage

>>> src/fnvdf_hash.sv
`timescale 1ns / 1ps
module fnvdf_hash
	import fnvdf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output logic [ID_W-1:0]   record_id,
	output logic              done_s1
);

	logic [ID_W-1:0]    hash_q;
	logic [COUNT_W-1:0] count_q;
	logic [ID_W-1:0]    fold;
	logic [ID_W-1:0]    lo_prod;
	logic [ID_W-1:0]    next_hash;
	logic               in_limit;
	logic [ID_W-1:0]    folded;

	// One FNV-1a round: xor the byte in, then multiply by the prime modulo 2^64.
	always_comb begin
		in_limit  = count_q < COUNT_W'(HASH_BYTE_LIMIT);
		fold      = hash_q ^ {{(ID_W-BYTE_W){1'b0}}, data_byte};
		lo_prod   = fold * FNV_PRIME_LO;
		next_hash = lo_prod + (fold << FNV_PRIME_SHIFT);
		folded    = in_limit ? next_hash : hash_q;
	end

	// Accumulator and byte count; both restart after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= FNV_BASIS;
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept && last_byte;
			if (accept) begin
				if (last_byte) begin
					hash_q  <= FNV_BASIS;
					count_q <= '0;
				end else begin
					hash_q <= folded;
					if (in_limit) begin
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	// The finished id is held until the next record completes.
	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			record_id <= folded;
		end
	end

endmodule

>>> src/fnvdf_cell.sv
`timescale 1ns / 1ps
module fnvdf_cell
	import fnvdf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctrl_t      ctrl,
	input  logic [ID_W-1:0] id_in,
	input  logic            valid_in,
	input  logic [ID_W-1:0] query,
	output logic [ID_W-1:0] id_out,
	output logic            valid_out,
	output logic            match_q
);

	logic [ID_W-1:0] id_q;
	logic            valid_q;

	// The valid bit moves along the chain with its id.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			match_q <= valid_q && (id_q == query);
			if (ctrl.shift) begin
				valid_q <= valid_in;
			end
		end
	end

	// Stored id takes the neighbour's value on a shift.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			id_q <= id_in;
		end
	end

	assign id_out    = id_q;
	assign valid_out = valid_q;

endmodule

>>> src/fnv1a_duplicate_record_filter_top.sv
`timescale 1ns / 1ps
// Takes one record byte per cycle, but s_axis_tready is low from the accepted last byte
// until that record is decided. The result passes the hash register, the registered
// compare in every window cell and the output register of the decision stage.
// A result waiting at the output stalls the next record only at its decision stage.
// Asynchronous active-low reset restores the hash basis, clears the byte count and
// invalidates every window cell; stored ids are not cleared.
module fnv1a_duplicate_record_filter_top
	import fnvdf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [ID_W-1:0]   m_axis_tdata,  // [63:0] record_id
	output logic              m_axis_tuser   // [0] is_duplicate
);

	logic                  accept;
	logic                  busy_q;
	logic                  done_s1;
	logic                  lookup_s2;
	logic [ID_W-1:0]       record_id;
	logic                  out_free;
	logic                  decide;
	logic                  dup;
	cell_ctrl_t            ctrl;
	logic [ID_W-1:0]       chain_id [WINDOW_DEPTH+1];
	logic [WINDOW_DEPTH:0] chain_valid;
	logic [WINDOW_DEPTH-1:0] match;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	fnvdf_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.record_id (record_id),
		.done_s1   (done_s1)
	);

	// Decision: once the output is free the output register loads; the window shifts only for a new id.
	always_comb begin
		out_free   = !m_axis_tvalid || m_axis_tready;
		decide     = lookup_s2 && out_free;
		dup        = |match;
		ctrl.shift = decide && !dup;
	end

	// New ids enter at the head; the oldest falls off the tail when the chain is full.
	assign chain_id[0]    = record_id;
	assign chain_valid[0] = 1'b1;

	for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
		fnvdf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.id_in     (chain_id[k]),
			.valid_in  (chain_valid[k]),
			.query     (record_id),
			.id_out    (chain_id[k+1]),
			.valid_out (chain_valid[k+1]),
			.match_q   (match[k])
		);
	end

	// Record sequencing and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			lookup_s2     <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (accept && s_axis_tlast) begin
				busy_q <= 1'b1;
			end else if (decide) begin
				busy_q <= 1'b0;
			end
			if (done_s1) begin
				lookup_s2 <= 1'b1;
			end else if (decide) begin
				lookup_s2 <= 1'b0;
			end
			if (decide) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (decide) begin
			m_axis_tdata <= record_id;
			m_axis_tuser <= dup;
		end
	end

endmodule
